### design/schb_pkg.sv
// Package for the string CRC hash bucket unit: hash constants, widths and
// the single shift/XOR round of the reflected CRC. No dependencies.
package schb_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned HASH_W   = 32;
   localparam int unsigned COUNT_W  = 25;
   localparam int unsigned INDEX_W  = 24;
   localparam int unsigned ROUND_W  = 3;
   localparam int unsigned STEP_W   = 5;

   localparam logic [HASH_W-1:0]  HASH_POLY    = 32'hAED0_0022;
   localparam logic [HASH_W-1:0]  HASH_INIT    = 32'hAED0_2022;
   localparam logic [COUNT_W-1:0] MAX_BUCKETS  = 25'h100_0000;
   localparam logic [COUNT_W-1:0] BUCKET_RESET = 25'd500;
   localparam logic [BYTE_W-1:0]  END_BYTE     = 8'h00;

   // One round of the reflected table generator.
   function automatic logic [HASH_W-1:0] crc_round(input logic [HASH_W-1:0] v);
      logic [HASH_W-1:0] r;
      r = v >> 1;
      if (v[0]) begin
         r = r ^ HASH_POLY;
      end
      return r;
   endfunction

endpackage

### design/string_crc_hash_bucket_unit.sv
// String CRC hash and bucket selector, top level.
// Depends on schb_pkg for constants and the CRC round function.

// One string byte per request. A nonzero byte runs eight shift/XOR rounds
// of the reflected CRC table generator, one round per cycle, and the block
// is busy until the last round. A zero byte ends the string: the hash is
// divided by the bucket count in a restoring divider, one quotient bit per
// cycle, then, once the output side is free, the hash and remainder go to
// the output register. bucket_count above 16777216 saturates to 16777216,
// and a count of zero gives bucket index 0. The running hash reloads
// 0xAED02022 at each string end. csr_ready is always high; write the bucket
// count only while the block is idle.
module string_crc_hash_bucket_unit
   import schb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [BYTE_W-1:0]  req_text_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [HASH_W-1:0]  rsp_hash_value,
   output logic [INDEX_W-1:0] rsp_bucket_index,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_bucket_count
);

   typedef enum logic [1:0] {ST_IDLE, ST_CRC, ST_DIV, ST_DONE} state_type;

   state_type          state_ff, state_in;
   logic [HASH_W-1:0]  hash_ff, hash_in;
   logic [HASH_W-1:0]  crc_ff, crc_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [HASH_W-1:0]  work_hash_ff, work_hash_in;
   logic [HASH_W-1:0]  shift_ff, shift_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0] divisor_ff, divisor_in;
   logic [COUNT_W-1:0] bucket_count_ff, bucket_count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [HASH_W-1:0]  rsp_hash_ff, rsp_hash_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;

   logic               req_accept;
   logic               out_free;
   logic [HASH_W-1:0]  crc_next;
   logic [COUNT_W:0]   trial;
   logic [COUNT_W:0]   trial_diff;

   assign req_stall        = (state_ff != ST_IDLE);
   assign req_accept       = req_valid && !req_stall;
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hash_value   = rsp_hash_ff;
   assign rsp_bucket_index = rsp_index_ff;
   assign out_free         = !rsp_valid_ff || !rsp_stall;

   assign crc_next   = crc_round(crc_ff);
   assign trial      = {rem_ff, shift_ff[HASH_W-1]};
   assign trial_diff = trial - {1'b0, divisor_ff};

   always_comb begin
      state_in        = state_ff;
      hash_in         = hash_ff;
      crc_in          = crc_ff;
      byte_in         = byte_ff;
      round_in        = round_ff;
      step_in         = step_ff;
      work_hash_in    = work_hash_ff;
      shift_in        = shift_ff;
      rem_in          = rem_ff;
      divisor_in      = divisor_ff;
      bucket_count_in = bucket_count_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_hash_in     = rsp_hash_ff;
      rsp_index_in    = rsp_index_ff;

      if (csr_valid && csr_ready) begin
         bucket_count_in = csr_bucket_count;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_text_byte != END_BYTE) begin
                  crc_in   = {{(HASH_W-BYTE_W){1'b0}}, hash_ff[BYTE_W-1:0]};
                  byte_in  = req_text_byte;
                  round_in = '0;
                  state_in = ST_CRC;
               end else begin
                  work_hash_in = hash_ff;
                  shift_in     = hash_ff;
                  rem_in       = '0;
                  step_in      = '0;
                  divisor_in   = (bucket_count_ff > MAX_BUCKETS) ? MAX_BUCKETS
                                                                 : bucket_count_ff;
                  hash_in      = HASH_INIT;
                  state_in     = ST_DIV;
               end
            end
         end
         ST_CRC: begin
            crc_in   = crc_next;
            round_in = round_ff + 1'b1;
            if (round_ff == '1) begin
               hash_in  = (hash_ff >> BYTE_W) ^ crc_next
                        ^ {byte_ff, {(HASH_W-BYTE_W){1'b0}}};
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            // restoring step: one quotient bit, remainder stays below divisor
            if (trial >= {1'b0, divisor_ff}) begin
               rem_in = trial_diff[COUNT_W-1:0];
            end else begin
               rem_in = trial[COUNT_W-1:0];
            end
            shift_in = shift_ff << 1;
            step_in  = step_ff + 1'b1;
            if (step_ff == '1) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = work_hash_ff;
               rsp_index_in = (divisor_ff == '0) ? '0 : rem_ff[INDEX_W-1:0];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         hash_ff         <= HASH_INIT;
         bucket_count_ff <= BUCKET_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         hash_ff         <= hash_in;
         bucket_count_ff <= bucket_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      crc_ff       <= crc_in;
      byte_ff      <= byte_in;
      round_ff     <= round_in;
      step_ff      <= step_in;
      work_hash_ff <= work_hash_in;
      shift_ff     <= shift_in;
      rem_ff       <= rem_in;
      divisor_ff   <= divisor_in;
      rsp_hash_ff  <= rsp_hash_in;
      rsp_index_ff <= rsp_index_in;
   end

   // end of string starts the divider and reloads the running hash
   a_end_starts_div: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_text_byte == END_BYTE) |=>
         (state_ff == ST_DIV && hash_ff == HASH_INIT))
      else $error("string end did not start the divider");

   // divisor is saturated while dividing
   a_divisor_sat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (divisor_ff <= MAX_BUCKETS))
      else $error("divisor above bucket limit");

   // remainder stays below a nonzero divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && divisor_ff != '0) |-> (rem_ff < divisor_ff))
      else $error("remainder not reduced");

   // a new response carries the hash of the finished string
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=>
         (rsp_valid_ff && rsp_hash_ff == $past(work_hash_ff)))
      else $error("response not loaded from finished string");

endmodule

### tb/string_crc_hash_bucket_unit_test.sv
// Self-checking testbench for string_crc_hash_bucket_unit: byte-wise CRC hash
// and bucket index, predicted in place and checked per response.
// Depends on schb_pkg and the string_crc_hash_bucket_unit RTL.
`timescale 1ns / 100ps

module string_crc_hash_bucket_unit_test;
   import schb_pkg::*;

   localparam int SETTLE_CYCLES  = 48;    // longer than the longest request
   localparam int WATCHDOG_LIMIT = 4000;  // covers the receiver hold-off (HOLD_CYCLES)
   localparam int HOLD_CYCLES    = 400;

   typedef struct packed {
      logic [HASH_W-1:0]  hash;
      logic [INDEX_W-1:0] bucket;
   } digest_type;

   logic               clock;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic [BYTE_W-1:0]  req_text_byte    = '0;
   logic               rsp_valid;
   logic               rsp_stall        = 1'b0;
   logic [HASH_W-1:0]  rsp_hash_value;
   logic [INDEX_W-1:0] rsp_bucket_index;
   logic               csr_valid        = 1'b0;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_bucket_count = '0;

   // predictor state
   logic [HASH_W-1:0]  crc_state  = HASH_INIT;
   logic [COUNT_W-1:0] bucket_cfg = BUCKET_RESET;
   digest_type         digest_q[$];

   int errors        = 0;
   int bytes_sent    = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_token    = 0;
   int idle_cycles   = 0;

   string_crc_hash_bucket_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hash_value   (rsp_hash_value),
      .rsp_bucket_index (rsp_bucket_index),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_bucket_count (csr_bucket_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [HASH_W-1:0] fold_byte(input logic [HASH_W-1:0] h,
                                                  input logic [BYTE_W-1:0] b);
      logic [HASH_W-1:0] t;
      int                r;
      t = {24'b0, h[7:0]};
      for (r = 0; r < 8; r++) begin
         if (t[0]) begin
            t = (t >> 1) ^ HASH_POLY;
         end else begin
            t = t >> 1;
         end
      end
      return (h >> 8) ^ t ^ {b, 24'b0};
   endfunction

   function automatic logic [INDEX_W-1:0] bucket_of(input logic [HASH_W-1:0] h,
                                                   input logic [COUNT_W-1:0] n);
      logic [COUNT_W-1:0] d;
      logic [HASH_W-1:0]  rem;
      d = (n > MAX_BUCKETS) ? MAX_BUCKETS : n;
      if (d == '0) begin
         return '0;
      end
      rem = h % {7'b0, d};
      return rem[INDEX_W-1:0];
   endfunction

   function automatic void absorb_byte(input logic [BYTE_W-1:0] b);
      digest_type d;
      if (b != END_BYTE) begin
         crc_state = fold_byte(crc_state, b);
      end else begin
         d.hash   = crc_state;
         d.bucket = bucket_of(crc_state, bucket_cfg);
         digest_q.push_back(d);
         crc_state = HASH_INIT;
      end
   endfunction

   // ---------------------------------------------------------------- driving

   // Called and returns at a falling edge; req_valid is left high so the next
   // request can follow back to back.
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= b;
      do @(posedge clock); while (req_stall);
      absorb_byte(b);
      bytes_sent++;
      @(negedge clock);
   endtask

   function automatic logic [BYTE_W-1:0] text_char();
      case ($urandom_range(7))
         0:       return 8'hFF;
         1:       return 8'h80;
         2:       return 8'h01;
         default: return BYTE_W'($urandom_range(1, 255));
      endcase
   endfunction

   task automatic send_string(input int len);
      for (int i = 0; i < len; i++) begin
         send_byte(text_char());
      end
      send_byte(END_BYTE);
   endtask

   function automatic int string_len();
      if ($urandom_range(9) == 0) begin
         return $urandom_range(12, 40);
      end
      return $urandom_range(0, 6);
   endfunction

   // Drop valid, drain every expected response, then give trailing work time.
   task automatic settle_block();
      req_valid <= 1'b0;
      while (digest_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_bucket_count(input logic [COUNT_W-1:0] n);
      settle_block();
      csr_valid        <= 1'b1;
      csr_bucket_count <= n;
      do @(posedge clock); while (!csr_ready);
      bucket_cfg = n;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------- response side

   always @(negedge clock) begin
      int hold_left;
      int token_seen;
      if (hold_token != token_seen) begin
         token_seen = hold_token;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      digest_type d;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (digest_q.size() == 0) begin
            $display("%0t: unexpected response hash %h bucket %h",
                     $time, rsp_hash_value, rsp_bucket_index);
            errors++;
         end else begin
            d = digest_q.pop_front();
            if (rsp_hash_value !== d.hash) begin
               $display("%0t: hash_value expected %h actual %h",
                        $time, d.hash, rsp_hash_value);
               errors++;
            end
            if (rsp_bucket_index !== d.bucket) begin
               $display("%0t: bucket_index expected %h actual %h",
                        $time, d.bucket, rsp_bucket_index);
               errors++;
            end
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
      begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
         $display("string_crc_hash_bucket_unit verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests

   // Runs on the reset bucket count of 500.
   task automatic test_directed_strings();
      send_byte(END_BYTE);                    // empty string gives the seed
      send_byte(8'h01); send_byte(END_BYTE);
      send_byte(8'hFF); send_byte(END_BYTE);
      send_byte(8'h80); send_byte(8'h7F); send_byte(END_BYTE);
      send_byte(8'h55); send_byte(8'hAA); send_byte(END_BYTE);
      send_byte(END_BYTE);                    // empty string right after another string end
      for (int i = 0; i < 8; i++) begin
         send_byte(8'h01 << i);               // walking one
      end
      send_byte(END_BYTE);
   endtask

   task automatic test_bucket_extremes();
      logic [COUNT_W-1:0] counts[8];
      counts = '{25'd1, 25'd0, MAX_BUCKETS, MAX_BUCKETS + 25'd1, '1,
                 25'd2, MAX_BUCKETS - 25'd1, 25'd3};
      recv_idle_pct = 25;
      foreach (counts[k]) begin
         write_bucket_count(counts[k]);
         send_string(0);
         send_string($urandom_range(1, 4));
         send_string($urandom_range(4, 10));
      end
   endtask

   task automatic run_random_phase(input int send_pct, input int recv_pct,
                                   input logic [COUNT_W-1:0] count, input int items);
      int stop_at;
      write_bucket_count(count);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      stop_at = bytes_sent + items;
      while (bytes_sent < stop_at) begin
         send_string(string_len());
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(19, 61, COUNT_W'($urandom_range(1, 1000)), 140);
      run_random_phase(61, 19, COUNT_W'($urandom_range(1, 16777216)), 140);
      run_random_phase(0, 0, COUNT_W'($urandom), 140);
   endtask

   // Receiver holds off while short strings keep coming, so responses back up
   // and the block must stall its input.
   task automatic test_output_backpressure();
      write_bucket_count(COUNT_W'($urandom_range(1, 65536)));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      @(posedge clock);
      hold_token++;
      @(negedge clock);
      for (int i = 0; i < 20; i++) begin
         send_string($urandom_range(0, 2));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed_strings();
      test_bucket_extremes();
      test_random_traffic();
      test_output_backpressure();

      settle_block();
      if (errors == 0) begin
         $display("string_crc_hash_bucket_unit verification clean");
      end else begin
         $display("string_crc_hash_bucket_unit verification failed");
      end
      $finish;
   end

endmodule

### sim.f
design/schb_pkg.sv
design/string_crc_hash_bucket_unit.sv
tb/string_crc_hash_bucket_unit_test.sv
